@@ rtl/hsvrgb_pkg.sv @@
`timescale 1ns / 1ps

package hsvrgb_pkg;

	typedef struct packed {
		logic [8:0] hue_deg;
		logic [6:0] sat_pct;
		logic [6:0] val_pct;
	} hsv_beat_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_beat_t;

	// hue sectors of 60 degrees
	localparam logic [2:0] SEC_RED_YEL  = 3'd0;
	localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
	localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
	localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
	localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
	localparam logic [2:0] SEC_MAG_RED  = 3'd5;

	localparam logic [8:0] HUE_MAX = 9'd359;
	localparam logic [6:0] PCT_MAX = 7'd100;

	localparam int VV_W   = 15;             // v*255
	localparam int K_W    = 13;             // weight in 1/6000 of full scale
	localparam int N_W    = VV_W + K_W;     // v*255*k
	localparam int SHIFT  = 6;              // 600000 = 64 * 9375
	localparam int NS_W   = N_W - SHIFT;
	localparam int M_W    = 23;
	localparam int P_SH   = 36;
	localparam int PROD_W = NS_W + M_W;

	localparam logic [K_W-1:0] TOP_K   = 13'd6000;
	localparam logic [K_W-1:0] SIXTY_K = 13'd60;
	localparam logic [VV_W-1:0] V_MUL  = 15'd255;
	// ceil(2^36 / 9375), exact quotient for dividends below 2^22
	localparam logic [M_W-1:0] RECIP_M = 23'd7330078;

endpackage

@@ rtl/hsv_to_rgb_percent_top.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle while out_ready stays high; each stage
// holds its beat only while the stage after it is full and stalled, so
// bubbles collapse under backpressure.
// Sets of the rate: the v*255*k multiply and the reciprocal multiply each take
// a stage of their own. Reset clears the stage valid bits only.
module hsv_to_rgb_percent_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hsvrgb_pkg::hsv_beat_t in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hsvrgb_pkg::rgb_beat_t out_data
);
	import hsvrgb_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5 = !vld_s5 || out_ready;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: clamp and split the hue into sector and remainder
	logic [8:0] hue_c;
	logic [6:0] sat_c, val_c;
	logic [2:0] sec_c;
	logic [8:0] off_c;
	logic [8:0] rem_c;

	always_comb begin
		hue_c = (in_data.hue_deg > HUE_MAX) ? HUE_MAX : in_data.hue_deg;
		sat_c = (in_data.sat_pct > PCT_MAX) ? PCT_MAX : in_data.sat_pct;
		val_c = (in_data.val_pct > PCT_MAX) ? PCT_MAX : in_data.val_pct;
		if (hue_c >= 9'd300) begin
			sec_c = SEC_MAG_RED;
			off_c = 9'd300;
		end else if (hue_c >= 9'd240) begin
			sec_c = SEC_BLU_MAG;
			off_c = 9'd240;
		end else if (hue_c >= 9'd180) begin
			sec_c = SEC_CYN_BLU;
			off_c = 9'd180;
		end else if (hue_c >= 9'd120) begin
			sec_c = SEC_GRN_CYN;
			off_c = 9'd120;
		end else if (hue_c >= 9'd60) begin
			sec_c = SEC_YEL_GRN;
			off_c = 9'd60;
		end else begin
			sec_c = SEC_RED_YEL;
			off_c = 9'd0;
		end
		rem_c = hue_c - off_c;
	end

	logic [2:0] sec_s1;
	logic [5:0] rem_s1;
	logic [6:0] sat_s1, val_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			sec_s1 <= sec_c;
			rem_s1 <= rem_c[5:0];
			sat_s1 <= sat_c;
			val_s1 <= val_c;
		end
	end

	// stage 2: small products
	logic [2:0]      sec_s2;
	logic [VV_W-1:0] vv_s2;
	logic [K_W-1:0]  sr_s2;
	logic [K_W-1:0]  base_s2;
	logic [6:0]      unsat;

	assign unsat = PCT_MAX - sat_s1;

	always_ff @(posedge clk) begin
		if (adv2) begin
			sec_s2  <= sec_s1;
			vv_s2   <= {{(VV_W-7){1'b0}}, val_s1} * V_MUL;
			sr_s2   <= {{(K_W-7){1'b0}}, sat_s1} * {{(K_W-6){1'b0}}, rem_s1};
			base_s2 <= {{(K_W-7){1'b0}}, unsat} * SIXTY_K;
		end
	end

	// stage 3: pick each channel's weight
	logic [K_W-1:0] rise_k, fall_k;
	logic [K_W-1:0] kr_c, kg_c, kb_c;

	always_comb begin
		rise_k = base_s2 + sr_s2;
		fall_k = TOP_K - sr_s2;
		case (sec_s2)
			SEC_RED_YEL: begin kr_c = TOP_K;   kg_c = rise_k;  kb_c = base_s2; end
			SEC_YEL_GRN: begin kr_c = fall_k;  kg_c = TOP_K;   kb_c = base_s2; end
			SEC_GRN_CYN: begin kr_c = base_s2; kg_c = TOP_K;   kb_c = rise_k;  end
			SEC_CYN_BLU: begin kr_c = base_s2; kg_c = fall_k;  kb_c = TOP_K;   end
			SEC_BLU_MAG: begin kr_c = rise_k;  kg_c = base_s2; kb_c = TOP_K;   end
			default:     begin kr_c = TOP_K;   kg_c = base_s2; kb_c = fall_k;  end
		endcase
	end

	logic [VV_W-1:0] vv_s3;
	logic [K_W-1:0]  kr_s3, kg_s3, kb_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			vv_s3 <= vv_s2;
			kr_s3 <= kr_c;
			kg_s3 <= kg_c;
			kb_s3 <= kb_c;
		end
	end

	// stage 4: scaled value, drop the power-of-two part of the divisor
	logic [N_W-1:0] nr_c, ng_c, nb_c;

	assign nr_c = {{K_W{1'b0}}, vv_s3} * {{VV_W{1'b0}}, kr_s3};
	assign ng_c = {{K_W{1'b0}}, vv_s3} * {{VV_W{1'b0}}, kg_s3};
	assign nb_c = {{K_W{1'b0}}, vv_s3} * {{VV_W{1'b0}}, kb_s3};

	logic [NS_W-1:0] nr_s4, ng_s4, nb_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			nr_s4 <= nr_c[N_W-1:SHIFT];
			ng_s4 <= ng_c[N_W-1:SHIFT];
			nb_s4 <= nb_c[N_W-1:SHIFT];
		end
	end

	// stage 5: divide by 9375 through the reciprocal
	logic [PROD_W-1:0] pr_c, pg_c, pb_c;

	assign pr_c = {{M_W{1'b0}}, nr_s4} * {{NS_W{1'b0}}, RECIP_M};
	assign pg_c = {{M_W{1'b0}}, ng_s4} * {{NS_W{1'b0}}, RECIP_M};
	assign pb_c = {{M_W{1'b0}}, nb_s4} * {{NS_W{1'b0}}, RECIP_M};

	rgb_beat_t rgb_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			rgb_s5.red_out   <= pr_c[P_SH+7:P_SH];
			rgb_s5.green_out <= pg_c[P_SH+7:P_SH];
			rgb_s5.blue_out  <= pb_c[P_SH+7:P_SH];
		end
	end

	assign out_valid = vld_s5;
	assign out_data  = rgb_s5;

endmodule

@@ bench/tb_hsv_to_rgb_percent_top.sv @@
`timescale 1ns / 1ps

module tb_hsv_to_rgb_percent_top;
	import hsvrgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int RANDOM_PER_PHASE = 367;
	localparam longint unsigned FULL_SCALE = 600000;

	// hue, sat, val, known, red, green, blue
	typedef struct packed {
		hsv_beat_t hsv;
		logic      known;
		rgb_beat_t rgb;
	} hsv_case_t;

	localparam int N_DIRECTED = 25;
	localparam hsv_case_t DIRECTED [N_DIRECTED] = '{
		{9'd0,   7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		{9'd0,   7'd0,   7'd100, 1'b1, 8'd255, 8'd255, 8'd255},
		{9'd0,   7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd0},
		{9'd60,  7'd100, 7'd100, 1'b1, 8'd255, 8'd255, 8'd0},
		{9'd120, 7'd100, 7'd100, 1'b1, 8'd0,   8'd255, 8'd0},
		{9'd180, 7'd100, 7'd100, 1'b1, 8'd0,   8'd255, 8'd255},
		{9'd240, 7'd100, 7'd100, 1'b1, 8'd0,   8'd0,   8'd255},
		{9'd300, 7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd255},
		{9'd359, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd511, 7'd127, 7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd360, 7'd101, 7'd101, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd30,  7'd50,  7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
		{9'd90,  7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd150, 7'd75,  7'd80,  1'b0, 8'd0,   8'd0,   8'd0},
		{9'd210, 7'd25,  7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd270, 7'd100, 7'd60,  1'b0, 8'd0,   8'd0,   8'd0},
		{9'd330, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd59,  7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd119, 7'd1,   7'd1,   1'b0, 8'd0,   8'd0,   8'd0},
		{9'd200, 7'd127, 7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		{9'd45,  7'd0,   7'd127, 1'b1, 8'd255, 8'd255, 8'd255},
		{9'd256, 7'd64,  7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
		{9'd179, 7'd99,  7'd99,  1'b0, 8'd0,   8'd0,   8'd0},
		{9'd299, 7'd0,   7'd37,  1'b0, 8'd0,   8'd0,   8'd0},
		{9'd0,   7'd127, 7'd1,   1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	hsv_beat_t in_data;
	logic      out_valid;
	logic      out_ready;
	rgb_beat_t out_data;

	rgb_beat_t rgb_pending [$];
	int        mismatch_count = 0;
	int        stall_cycles = 0;
	int        snd_idle_pct = 0;
	int        rcv_idle_pct = 0;

	hsv_to_rgb_percent_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic rgb_beat_t rgb_from_hsv(input hsv_beat_t c);
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] val;
		logic [2:0] sector;
		longint unsigned rem, peak, floor_lvl, ramp, rise, fall, r, g, b;
		rgb_beat_t res;
		hue = (c.hue_deg > HUE_MAX) ? HUE_MAX : c.hue_deg;
		sat = (c.sat_pct > PCT_MAX) ? PCT_MAX : c.sat_pct;
		val = (c.val_pct > PCT_MAX) ? PCT_MAX : c.val_pct;
		sector = 3'(hue / 60);
		rem = longint'(hue % 60);
		// everything in units of 1/600000 of one output step
		peak = longint'(val) * 1530000;
		floor_lvl = longint'(val) * 255 * (100 - longint'(sat)) * 60;
		ramp = longint'(val) * 255 * longint'(sat) * rem;
		rise = floor_lvl + ramp;
		fall = peak - ramp;
		case (sector)
			SEC_RED_YEL: begin r = peak;      g = rise;      b = floor_lvl; end
			SEC_YEL_GRN: begin r = fall;      g = peak;      b = floor_lvl; end
			SEC_GRN_CYN: begin r = floor_lvl; g = peak;      b = rise;      end
			SEC_CYN_BLU: begin r = floor_lvl; g = fall;      b = peak;      end
			SEC_BLU_MAG: begin r = rise;      g = floor_lvl; b = peak;      end
			default:     begin r = peak;      g = floor_lvl; b = fall;      end
		endcase
		res.red_out   = 8'(r / FULL_SCALE);
		res.green_out = 8'(g / FULL_SCALE);
		res.blue_out  = 8'(b / FULL_SCALE);
		return res;
	endfunction

	function automatic logic [6:0] pick_pct();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 7'd0;
		else if (sel == 1)
			return PCT_MAX;
		else if (sel == 2)
			return 7'($urandom);
		else
			return 7'($urandom_range(0, 100));
	endfunction

	function automatic hsv_beat_t pick_hsv();
		hsv_beat_t c;
		c.hue_deg = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
		c.sat_pct = pick_pct();
		c.val_pct = pick_pct();
		return c;
	endfunction

	task automatic send_hsv(input hsv_beat_t beat, input rgb_beat_t want);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rgb_pending.push_back(want);
	endtask

	// hold the sender off until every outstanding beat has come back
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rgb_pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int count);
		hsv_beat_t c;
		for (int n = 0; n < count; n++) begin
			c = pick_hsv();
			send_hsv(c, rgb_from_hsv(c));
		end
	endtask

	// receiver: random backpressure, check each output beat against the oldest expectation
	always @(posedge clk) begin
		rgb_beat_t want;
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		if (out_valid && out_ready) begin
			if (rgb_pending.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected rgb beat %0d/%0d/%0d", out_data.red_out,
						out_data.green_out, out_data.blue_out);
			end else begin
				want = rgb_pending.pop_front();
				if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
						out_data.blue_out !== want.blue_out) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("rgb mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.red_out, want.green_out, want.blue_out,
							out_data.red_out, out_data.green_out, out_data.blue_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("hsv_to_rgb_percent_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 38;
		rcv_idle_pct = 88;
		for (int i = 0; i < N_DIRECTED; i++)
			send_hsv(DIRECTED[i].hsv,
				DIRECTED[i].known ? DIRECTED[i].rgb : rgb_from_hsv(DIRECTED[i].hsv));
		drain_pipe();

		run_random(RANDOM_PER_PHASE / 2);
		drain_pipe();
		run_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
		drain_pipe();

		snd_idle_pct = 88;
		rcv_idle_pct = 38;
		run_random(RANDOM_PER_PHASE);
		drain_pipe();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_random(RANDOM_PER_PHASE);
		drain_pipe();

		// catch any stray beats behind the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && rgb_pending.size() == 0)
			$display("hsv_to_rgb_percent_top verification clean");
		else
			$display("hsv_to_rgb_percent_top verification failed");
		$finish;
	end

endmodule

@@ hsv_to_rgb_percent_top.f @@
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_percent_top.sv
bench/tb_hsv_to_rgb_percent_top.sv
